FILE: hdl/sitda_pkg.sv
// shared constants and types for the signed integer to decimal ascii unit
// no dependencies; imported by sitda_bcd_unit and the top level
package sitda_pkg;

  // width of the signed input word
  localparam int DATA_WIDTH = 32;

  // decimal digits kept in the bcd register, an upper bound on digits of 2^(DATA_WIDTH-1)
  localparam int NUM_DIGITS = (DATA_WIDTH * 3 + 9) / 10;
  localparam int BCD_W      = NUM_DIGITS * 4;

  // counter widths
  localparam int CNT_W = $clog2(DATA_WIDTH + 1);
  localparam int DIG_W = $clog2(NUM_DIGITS + 1);

  // ascii codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // command to the bcd unit, at most one bit set per cycle
  typedef struct packed {
    logic load;         // take a new magnitude, clear the digits
    logic dabble;       // one add-3 and shift step
    logic digit_shift;  // move digits up by one place
  } sitda_cmd_t;

endpackage

FILE: hdl/sitda_bcd_unit.sv
// bcd conversion unit: magnitude shift register plus bcd digit register
// one shared add-3 and shift step per cycle while cmd.dabble is set; depends on sitda_pkg
module sitda_bcd_unit import sitda_pkg::*; (
  input  logic                  clk,
  input  sitda_cmd_t            cmd,
  input  logic [DATA_WIDTH-1:0] mag_in,
  output logic [3:0]            top_digit
);

  logic [DATA_WIDTH-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;

  // add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // digit and magnitude registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= mag_in;
      bcd <= '0;
    end else if (cmd.dabble) begin
      bcd <= {bcd_adj[BCD_W-2:0], mag[DATA_WIDTH-1]};
      mag <= {mag[DATA_WIDTH-2:0], 1'b0};
    end else if (cmd.digit_shift) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
    end
  end

  assign top_digit = bcd[BCD_W-1 -: 4];

endmodule

FILE: hdl/signed_int_to_decimal_ascii_unit.sv
// signed integer to decimal ascii, top level: sequencer and output register
// depends on sitda_pkg and sitda_bcd_unit
//
// usage:
//   input channel (value, in_valid, in_stall): one beat is one signed integer.
//   in_stall is high while a number is being converted or printed.
//   output channel (char_code, last_char, out_valid, out_stall): one beat per
//   character, minus sign first for negative values, then digits from the most
//   significant, no leading zeros; last_char marks the final digit.
//   conversion: the unit runs DATA_WIDTH add-3 and shift steps on one shared
//   unit, then steps over leading zero digits one per cycle, then registers
//   the first character, sign or digit, which comes later for fewer digits,
//   then one character per cycle while out_stall is low. a new input beat is
//   accepted only after the last character of the number has been registered.
//   out_stall holds the output register and pauses printing; the pending
//   character stays unchanged until taken.
//   reset (rst, synchronous) returns to idle and drops out_valid.
module signed_int_to_decimal_ascii_unit import sitda_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic [7:0]                   char_code,
  output logic                         last_char,
  output logic                         out_valid,
  input  logic                         out_stall
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic [DIG_W-1:0]      dig_left;
  logic                  neg;
  logic                  accept;
  logic                  slot_free;
  logic [DATA_WIDTH-1:0] mag_in;
  logic [3:0]            top_digit;
  sitda_cmd_t            cmd;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // magnitude; the most negative value wraps to 2^(DATA_WIDTH-1) unsigned
  assign mag_in = value[DATA_WIDTH-1] ? (~value + 1'b1) : value;

  // unit commands
  always_comb begin
    cmd             = '0;
    cmd.load        = accept;
    cmd.dabble      = (state == ST_CONV);
    cmd.digit_shift = ((state == ST_SKIP) && (top_digit == 4'd0) && (dig_left > DIG_W'(1)))
                   || ((state == ST_EMIT) && slot_free);
  end

  sitda_bcd_unit u_bcd (
    .clk       (clk),
    .cmd       (cmd),
    .mag_in    (mag_in),
    .top_digit (top_digit)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      dig_left <= '0;
      neg      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            neg   <= value[DATA_WIDTH-1];
            cnt   <= CNT_W'(DATA_WIDTH);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            dig_left <= DIG_W'(NUM_DIGITS);
            state    <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if ((top_digit == 4'd0) && (dig_left > DIG_W'(1))) begin
            dig_left <= dig_left - 1'b1;
          end else if (neg) begin
            state <= ST_SIGN;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            dig_left <= dig_left - 1'b1;
            if (dig_left == DIG_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= (state == ST_SIGN) || (state == ST_EMIT);
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (state == ST_SIGN) begin
        char_code <= ASCII_MINUS;
        last_char <= 1'b0;
      end else if (state == ST_EMIT) begin
        char_code <= ASCII_ZERO + {4'd0, top_digit};
        last_char <= (dig_left == DIG_W'(1));
      end
    end
  end

endmodule

FILE: tb/tb.sv
// testbench for signed_int_to_decimal_ascii_unit: converts integers and checks every character
// depends on sitda_pkg and the unit's rtl; predicts the decimal text of each accepted value
module tb;
  import sitda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          IDLE_PCT    = 17;
  localparam int          DRAIN_WAIT  = 60;

  typedef logic signed [DATA_WIDTH-1:0] int_word_t;

  // one expected character of the printed number
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         in_valid;
  logic                         in_stall;
  logic [7:0]                   char_code;
  logic                         last_char;
  logic                         out_valid;
  logic                         out_stall;

  text_char_t  pending_chars[$];
  int unsigned error_count = 0;
  bit          idle_en     = 1'b1;
  int          hold_left   = 0;

  signed_int_to_decimal_ascii_unit dut (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  always #5 clk = ~clk;

  // decimal text of one value: sign first, then digits msd first, last one marked
  function automatic void queue_decimal_text(input int_word_t v);
    logic                  neg;
    logic [DATA_WIDTH-1:0] mag;
    logic [3:0]            digits[$];
    text_char_t            ch;
    neg = v[DATA_WIDTH-1];
    // most negative value wraps onto itself, which is the right unsigned magnitude
    mag = neg ? (~v + 1'b1) : v;
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != '0);
    if (neg) begin
      ch.code = ASCII_MINUS;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.code = ASCII_ZERO + 8'(digits[i]);
      ch.last = (i == digits.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  function automatic bit case_neg_flip();
    return $urandom_range(1) == 1;
  endfunction

  // random value spread over digit counts, signs and the range ends
  function automatic int_word_t pick_value();
    int_word_t v;
    case ($urandom_range(3))
      0: v = int_word_t'($urandom);
      1: v = int_word_t'($urandom_range(99));
      2: v = int_word_t'($urandom >> $urandom_range(DATA_WIDTH - 1));
      default: begin
        if ($urandom_range(1))
          v = int_word_t'({1'b1, {(DATA_WIDTH-1){1'b0}}}) + int_word_t'($urandom_range(3));
        else
          v = int_word_t'({1'b0, {(DATA_WIDTH-1){1'b1}}}) - int_word_t'($urandom_range(3));
      end
    endcase
    if (case_neg_flip()) v = -v;
    return v;
  endfunction

  // offer one beat and hold it until the unit takes it
  task automatic send_value(input int_word_t v);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    queue_decimal_text(v);
  endtask

  // range ends, zero, one digit, digit count boundaries
  task automatic test_directed();
    int_word_t vals[$];
    vals = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
             123456789, -987654321, 1000000000, -1000000000, 1999999999,
             32'sh7fffffff, 32'sh7ffffffe, 32'sh80000000, 32'sh80000001,
             32'sh55555555, 32'shaaaaaaaa};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // random values with idle gaps on both sides
  task automatic test_random_values(input int count);
    repeat (count) send_value(pick_value());
  endtask

  // back to back beats, no gaps anywhere
  task automatic test_no_gaps(input int count);
    idle_en = 1'b0;
    repeat (count) send_value(pick_value());
    idle_en = 1'b1;
  endtask

  // long receiver hold-off while beats keep coming, input must stall
  task automatic test_output_hold();
    hold_left = 400;
    repeat (10) send_value(pick_value());
  endtask

  // receiver: check each taken character, then pick the next stall
  initial begin
    text_char_t exp_ch;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected character beat: char_code %0d last_char %0b",
                 char_code, last_char);
          error_count++;
        end else begin
          exp_ch = pending_chars.pop_front();
          if (char_code !== exp_ch.code) begin
            $error("char_code: expected %0d, got %0d", exp_ch.code, char_code);
            error_count++;
          end
          if (last_char !== exp_ch.last) begin
            $error("last_char: expected %0b, got %0b", exp_ch.last, last_char);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // main sequence
  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    value    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_values(57);
    test_no_gaps(40);
    test_output_hold();
    test_random_values(30);

    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
